// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true at a clock edge
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

// ----- rtl/utta_pkg.sv -----
// Shared types and constants of the UTF-8 typography normalizer
`default_nettype none

package utta_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_EMIT        = 3;

    typedef struct packed {
        logic [MAX_EMIT-1:0][7:0] bytes;
        logic [1:0]               cnt;
        logic                     last;
    } t_entry;

endpackage

`default_nettype wire

// ----- rtl/utta_front.sv -----
// Front end: holds lookahead bytes, matches patterns and builds queue entries
`default_nettype none

module utta_front
    import utta_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire logic   i_full,
    input  wire logic [7:0] i_byte,
    input  wire logic   i_last,
    output logic        o_ready,
    output logic        o_push,
    output t_entry      o_entry
);

    `include "assert_macros.svh"

    localparam logic [1:0] MATCH_FAIL    = 2'd0;
    localparam logic [1:0] MATCH_PARTIAL = 2'd1;
    localparam logic [1:0] MATCH_FULL    = 2'd2;

    localparam logic [7:0] BOM_B0   = 8'hEF;
    localparam logic [7:0] BOM_B1   = 8'hBB;
    localparam logic [7:0] BOM_B2   = 8'hBF;
    localparam logic [7:0] LEAD_C2  = 8'hC2;
    localparam logic [7:0] LEAD_E2  = 8'hE2;
    localparam logic [7:0] MID_80   = 8'h80;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] len;
        logic [1:0] replen;
        logic [7:0] rep;
    } t_match;

    function automatic t_match classify(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [1:0] n,
                                        input logic st);
        t_match m;
        m = '{kind: MATCH_FAIL, len: 2'd1, replen: 2'd0, rep: 8'h00};
        if (b0 == BOM_B0 && st) begin
            if (n < 2'd2)              m.kind = MATCH_PARTIAL;
            else if (b1 != BOM_B1)     m.kind = MATCH_FAIL;
            else if (n < 2'd3)         m.kind = MATCH_PARTIAL;
            else if (b2 != BOM_B2)     m.kind = MATCH_FAIL;
            else begin
                m.kind = MATCH_FULL;
                m.len  = 2'd3;
            end
        end else if (b0 == LEAD_C2) begin
            if (n < 2'd2) begin
                m.kind = MATCH_PARTIAL;
            end else begin
                m.len    = 2'd2;
                m.replen = 2'd1;
                m.kind   = MATCH_FULL;
                case (b1)
                    8'hA0:        m.rep = CH_SPACE;
                    8'hAB, 8'hBB: m.rep = CH_QUOTE;
                    8'h91, 8'h92: m.rep = CH_APOS;
                    default: begin
                        m.kind = MATCH_FAIL;
                        m.len  = 2'd1;
                    end
                endcase
            end
        end else if (b0 == LEAD_E2) begin
            if (n < 2'd2)             m.kind = MATCH_PARTIAL;
            else if (b1 != MID_80)    m.kind = MATCH_FAIL;
            else if (n < 2'd3)        m.kind = MATCH_PARTIAL;
            else begin
                m.len    = 2'd3;
                m.replen = 2'd1;
                m.kind   = MATCH_FULL;
                case (b2)
                    8'h98, 8'h99, 8'h9A, 8'h9B:               m.rep = CH_APOS;
                    8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hB9, 8'hBA: m.rep = CH_QUOTE;
                    8'h93, 8'h94, 8'h95:                      m.rep = CH_DASH;
                    8'hA6: begin
                        m.rep    = CH_DOT;
                        m.replen = 2'd3;
                    end
                    default: begin
                        m.kind = MATCH_FAIL;
                        m.len  = 2'd1;
                    end
                endcase
            end
        end
        return m;
    endfunction

    logic [1:0][7:0] r_held;
    logic [1:0]      r_held_cnt;
    logic            r_start;

    logic [7:0]      w0, w1, w2;
    logic [1:0]      n_cnt;
    logic [1:0]      len;
    logic            st;
    logic            done;
    logic [1:0]      cnt;
    logic [MAX_EMIT-1:0][7:0] emit;
    t_match          m;
    logic            accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        w0   = (r_held_cnt != 2'd0) ? r_held[0] : i_byte;
        w1   = (r_held_cnt == 2'd2) ? r_held[1] : i_byte;
        w2   = i_byte;
        n_cnt = r_held_cnt + 2'd1;
        st   = r_start;
        done = 1'b0;
        cnt  = 2'd0;
        emit = '0;
        m    = '0;
        len  = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (!done && n_cnt != 2'd0) begin
                m = classify(w0, w1, w2, n_cnt, st);
                if (m.kind == MATCH_PARTIAL && !i_last) begin
                    done = 1'b1;
                end else begin
                    if (m.kind == MATCH_FULL) begin
                        len = m.len;
                        for (int k = 0; k < 3; k++) begin
                            if (2'(k) < m.replen && cnt != 2'd3) begin
                                emit[cnt] = m.rep;
                                cnt = cnt + 2'd1;
                            end
                        end
                    end else begin
                        len = 2'd1;
                        if (cnt != 2'd3) begin
                            emit[cnt] = w0;
                            cnt = cnt + 2'd1;
                        end
                    end
                    if (len > n_cnt) len = n_cnt;
                    case (len)
                        2'd1: begin
                            w0 = w1;
                            w1 = w2;
                        end
                        2'd2: w0 = w2;
                        default: ;
                    endcase
                    n_cnt = n_cnt - len;
                    st = 1'b0;
                end
            end
        end
    end

    assign o_push        = accept && (cnt != 2'd0 || i_last);
    assign o_entry.bytes = emit;
    assign o_entry.cnt   = cnt;
    assign o_entry.last  = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_start    <= 1'b1;
        end else if (accept) begin
            if (i_last) begin
                r_held_cnt <= 2'd0;
                r_start    <= 1'b1;
            end else begin
                r_held_cnt <= n_cnt;
                r_start    <= st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_last) begin
            r_held[0] <= w0;
            r_held[1] <= w1;
        end
    end

    `ASSERT_NEVER(a_held_bound, i_clk, i_rst_n, r_held_cnt == 2'd3,
        "more than two lookahead bytes held")
    `ASSERT_CLK(a_last_flushes, i_clk, i_rst_n,
        (accept && i_last) |=> (r_held_cnt == 2'd0 && r_start),
        "final beat did not flush the lookahead")

endmodule

`default_nettype wire

// ----- rtl/utta_fifo.sv -----
// Short queue of result entries between the front and back ends
`default_nettype none

module utta_fifo
    import utta_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_head
);

    `include "assert_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop,
        "push into full queue")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty,
        "pop from empty queue")

endmodule

`default_nettype wire

// ----- rtl/utta_back.sv -----
// Back end: expands queue entries into output beats through an output register
`default_nettype none

module utta_back
    import utta_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_empty,
    input  wire t_entry i_head,
    output logic        o_pop,
    input  wire logic   i_ready,
    output logic        o_valid,
    output logic [7:0]  o_data,
    output logic        o_last,
    output logic [1:0]  o_user
);

    `include "assert_macros.svh"

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_byte_valid;
    logic       r_end;

    logic       load;
    logic       fin;

    assign load  = !i_empty && (!r_valid || i_ready);
    assign fin   = (i_head.cnt == 2'd0) || (r_idx == i_head.cnt - 2'd1);
    assign o_pop = load && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= fin ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data       <= (i_head.cnt == 2'd0) ? 8'h00 : i_head.bytes[r_idx];
            r_byte_valid <= (i_head.cnt != 2'd0);
            r_last       <= fin;
            r_end        <= fin && i_head.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_user  = {r_end, r_byte_valid};

    `ASSERT_CLK(a_null_is_end, i_clk, i_rst_n,
        (r_valid && !r_byte_valid) |-> (r_last && r_end && r_data == 8'h00),
        "empty result without end marks")
    `ASSERT_NEVER(a_idx_needs_entry, i_clk, i_rst_n, r_idx != 2'd0 && i_empty,
        "entry split but queue empty")

endmodule

`default_nettype wire

// ----- rtl/utf8_typography_to_ascii.sv -----
// Top level of the UTF-8 typography to ASCII normalizer
// Usage:
//   Input stream s_axis: one UTF-8 byte per beat in tdata, tlast on the final
//   byte of a text. Output stream m_axis: one normalized byte per beat.
//   A leading byte-order mark is dropped; smart quotes, guillemets, dashes,
//   no-break space and the ellipsis become plain ASCII.
//   tlast marks the last output beat caused by one input byte; tuser[1]
//   marks the final beat of a text; tuser[0] clear means an empty beat that
//   only carries the end marks (data zero).
// Path: an output beat, made when the input beat that completes it is taken,
//   is written into the queue, then into the output register; bytes of an
//   unfinished pattern wait for the next byte.
// Throughput: one input beat per cycle. Each input beat makes zero to three
//   output beats, one per cycle while m_axis_tready is high; the output side drains the queue at one
//   beat per cycle, so the input stalls only when the queue of QUEUE_DEPTH
//   entries is full.
// Reset: synchronous, active low; clears the lookahead, the queue and the
//   output register, and arms byte-order mark detection.
// Stall: when m_axis_tready is low the output beat holds and the queue
//   fills; s_axis_tready drops once it is full.
`default_nettype none

module utf8_typography_to_ascii
    import utta_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,
    output logic [1:0]      m_axis_tuser    // [0] byte_valid, [1] text_end
);

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    utta_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_full  (full),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_entry (push_entry)
    );

    utta_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_entry)
    );

    utta_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_entry),
        .o_pop   (pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/tb_utf8_typography_to_ascii.sv -----
// Self-checking testbench for the UTF-8 typography to ASCII stream normalizer
module tb_utf8_typography_to_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] BOM_B0     = 8'hEF;
    localparam logic [7:0] BOM_B1     = 8'hBB;
    localparam logic [7:0] BOM_B2     = 8'hBF;
    localparam logic [7:0] LEAD2      = 8'hC2;
    localparam logic [7:0] LEAD3      = 8'hE2;
    localparam logic [7:0] MID3       = 8'h80;
    localparam logic [7:0] NBSP       = 8'hA0;
    localparam logic [7:0] LAQUO      = 8'hAB;
    localparam logic [7:0] RAQUO      = 8'hBB;
    localparam logic [7:0] PU1        = 8'h91;
    localparam logic [7:0] PU2        = 8'h92;
    localparam logic [7:0] SQ_FIRST   = 8'h98;
    localparam logic [7:0] SQ_LAST    = 8'h9B;
    localparam logic [7:0] DQ_FIRST   = 8'h9C;
    localparam logic [7:0] DQ_LAST    = 8'h9F;
    localparam logic [7:0] DQ_ALT0    = 8'hB9;
    localparam logic [7:0] DQ_ALT1    = 8'hBA;
    localparam logic [7:0] DASH_FIRST = 8'h93;
    localparam logic [7:0] DASH_LAST  = 8'h95;
    localparam logic [7:0] ELLIPSIS   = 8'hA6;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_HYPHEN  = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;

    localparam logic [4:0][7:0]  C2_TAILS = {NBSP, LAQUO, RAQUO, PU1, PU2};
    localparam logic [13:0][7:0] E2_TAILS = {8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D,
                                             8'h9E, 8'h9F, DQ_ALT0, DQ_ALT1, 8'h93,
                                             8'h94, 8'h95, ELLIPSIS};

    localparam int RANDOM_ITEMS   = 480;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT    = 2000;

    typedef enum logic [1:0] {SCAN_MISS, SCAN_PARTIAL, SCAN_HIT} t_scan;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       run_last;
        logic       text_end;
    } t_ascii_beat;

    class ascii_scoreboard;
        logic [7:0]  held [2];
        int          held_n;
        bit          at_start;
        t_ascii_beat ascii_beats_q [$];
        int          errors;

        function new();
            held_n   = 0;
            at_start = 1;
            errors   = 0;
        endfunction

        function t_scan match_pattern(input logic [7:0] w [3], input int n, input bit first,
                                      output int len, output logic [7:0] rep [3],
                                      output int rlen);
            len    = 1;
            rlen   = 1;
            rep[0] = 8'h00;
            rep[1] = CH_DOT;
            rep[2] = CH_DOT;
            if (w[0] == BOM_B0 && first) begin
                if (n < 2) return SCAN_PARTIAL;
                if (w[1] != BOM_B1) return SCAN_MISS;
                if (n < 3) return SCAN_PARTIAL;
                if (w[2] != BOM_B2) return SCAN_MISS;
                len  = 3;
                rlen = 0;
                return SCAN_HIT;
            end
            if (w[0] == LEAD2) begin
                if (n < 2) return SCAN_PARTIAL;
                len = 2;
                if (w[1] == NBSP) rep[0] = CH_SPACE;
                else if (w[1] == LAQUO || w[1] == RAQUO) rep[0] = CH_QUOTE;
                else if (w[1] == PU1 || w[1] == PU2) rep[0] = CH_APOS;
                else return SCAN_MISS;
                return SCAN_HIT;
            end
            if (w[0] == LEAD3) begin
                if (n < 2) return SCAN_PARTIAL;
                if (w[1] != MID3) return SCAN_MISS;
                if (n < 3) return SCAN_PARTIAL;
                len = 3;
                if (w[2] >= SQ_FIRST && w[2] <= SQ_LAST) begin
                    rep[0] = CH_APOS;
                end else if ((w[2] >= DQ_FIRST && w[2] <= DQ_LAST) ||
                             w[2] == DQ_ALT0 || w[2] == DQ_ALT1) begin
                    rep[0] = CH_QUOTE;
                end else if (w[2] >= DASH_FIRST && w[2] <= DASH_LAST) begin
                    rep[0] = CH_HYPHEN;
                end else if (w[2] == ELLIPSIS) begin
                    rep[0] = CH_DOT;
                    rlen   = 3;
                end else begin
                    return SCAN_MISS;
                end
                return SCAN_HIT;
            end
            return SCAN_MISS;
        endfunction

        function void note_byte(input logic [7:0] b, input logic fin);
            logic [7:0]  win [3];
            logic [7:0]  rep [3];
            logic [7:0]  emit [3];
            int          n;
            int          cnt;
            int          len;
            int          rlen;
            bit          first;
            t_scan       res;
            t_ascii_beat beat;
            for (int k = 0; k < held_n; k++) win[k] = held[k];
            n        = held_n;
            win[n]   = b;
            n++;
            first    = at_start;
            cnt      = 0;
            while (n > 0) begin
                res = match_pattern(win, n, first, len, rep, rlen);
                if (res == SCAN_PARTIAL && !fin) break;
                if (res == SCAN_HIT) begin
                    for (int k = 0; k < rlen; k++) begin
                        if (cnt < 3) begin
                            emit[cnt] = rep[k];
                            cnt++;
                        end
                    end
                end else begin
                    len = 1;
                    if (cnt < 3) begin
                        emit[cnt] = win[0];
                        cnt++;
                    end
                end
                if (len > n) len = n;
                for (int k = 0; k < n - len; k++) win[k] = win[k + len];
                n     -= len;
                first  = 0;
            end
            if (fin) begin
                held_n   = 0;
                at_start = 1;
            end else begin
                for (int k = 0; k < n; k++) held[k] = win[k];
                held_n   = n;
                at_start = first;
            end
            if (cnt == 0) begin
                if (fin) begin
                    beat = '{data: 8'h00, valid: 1'b0, run_last: 1'b1, text_end: 1'b1};
                    ascii_beats_q.push_back(beat);
                end
            end else begin
                for (int k = 0; k < cnt; k++) begin
                    beat.data     = emit[k];
                    beat.valid    = 1'b1;
                    beat.run_last = (k == cnt - 1);
                    beat.text_end = (k == cnt - 1) && fin;
                    ascii_beats_q.push_back(beat);
                end
            end
        endfunction

        task report(input string msg);
            errors++;
            $display("MISMATCH %0t: %s", $realtime, msg);
        endtask

        task check_beat(input logic [7:0] data, input logic tlast, input logic [1:0] tuser);
            t_ascii_beat want;
            if (ascii_beats_q.size() == 0) begin
                report($sformatf("beat with nothing pending: data %h tlast %b tuser %b",
                                 data, tlast, tuser));
            end else begin
                want = ascii_beats_q.pop_front();
                if (data !== want.data || tlast !== want.run_last ||
                    tuser[0] !== want.valid || tuser[1] !== want.text_end) begin
                    report($sformatf("got data %h tlast %b valid %b end %b, want %h %b %b %b",
                                     data, tlast, tuser[0], tuser[1], want.data,
                                     want.run_last, want.valid, want.text_end));
                end
            end
        endtask

        task close();
            if (ascii_beats_q.size() != 0)
                report($sformatf("%0d beats never arrived", ascii_beats_q.size()));
        endtask
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;            // [0] byte_valid, [1] text_end

    ascii_scoreboard sb;
    logic [7:0]      text_buf [$];
    bit              tx_fast     = 0;
    bit              rx_fast     = 0;
    int              rx_hold     = 0;
    int              stuck_count = 0;

    utf8_typography_to_ascii i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stuck_count = 0;
            end else begin
                stuck_count++;
                if (stuck_count >= STUCK_LIMIT) begin
                    $display("tb_utf8_typography_to_ascii: errors");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++)
            send_byte(text_buf[k], k == text_buf.size() - 1);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.ascii_beats_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_token();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: text_buf.push_back(8'($urandom_range(0, 255)));
            3: text_buf.push_back(8'($urandom_range(CH_SPACE, 8'h7E)));
            4: begin
                text_buf.push_back(LEAD2);
                if ($urandom_range(0, 5) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
                else text_buf.push_back(C2_TAILS[$urandom_range(0, 4)]);
            end
            5, 6: begin
                text_buf.push_back(LEAD3);
                text_buf.push_back(MID3);
                if ($urandom_range(0, 5) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
                else text_buf.push_back(E2_TAILS[$urandom_range(0, 13)]);
            end
            7: begin
                text_buf.push_back(LEAD3);
                text_buf.push_back(8'($urandom_range(0, 255)));
            end
            8: begin
                text_buf.push_back(BOM_B0);
                text_buf.push_back(BOM_B1);
                if ($urandom_range(0, 3) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
                else text_buf.push_back(BOM_B2);
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: text_buf.push_back(LEAD2);
                    1: text_buf.push_back(LEAD3);
                    default: text_buf.push_back(BOM_B0);
                endcase
            end
        endcase
    endfunction

    function automatic void build_text();
        int tokens;
        tokens = $urandom_range(1, 10);
        text_buf.delete();
        if ($urandom_range(0, 3) == 0) begin
            text_buf.push_back(BOM_B0);
            text_buf.push_back(BOM_B1);
            text_buf.push_back(BOM_B2);
        end
        repeat (tokens) add_token();
    endfunction

    initial begin : rx_proc
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            if ($urandom_range(0, 31) == 0) rx_fast = !rx_fast;
            stall = rx_fast ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin : tx_proc
        int random_sent;
        bit held_off;
        bit paused;
        random_sent = 0;
        held_off    = 0;
        paused      = 0;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // mark-only text, then no-break space, ellipsis, dash and guillemet rules plus failed partial matches
        text_buf = '{BOM_B0, BOM_B1, BOM_B2};
        send_text();
        text_buf = '{LEAD2, NBSP, LEAD3, MID3, ELLIPSIS, LEAD3, MID3, 8'h94, LEAD2, 8'h41,
                     LEAD3, LEAD2, LAQUO, BOM_B0, BOM_B1, BOM_B2, 8'h00, 8'hFF};
        send_text();
        // unfinished patterns flushed at text end
        text_buf = '{LEAD3, MID3};
        send_text();
        text_buf = '{BOM_B0, LEAD2};
        send_text();

        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= RANDOM_ITEMS / 3 && !held_off) begin
                rx_hold  = RX_HOLD_CYCLES;
                held_off = 1;
            end
            if (random_sent >= 2 * RANDOM_ITEMS / 3 && !paused) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                paused = 1;
            end
            build_text();
            tx_fast = ($urandom_range(0, 3) == 0);
            send_text();
            random_sent += text_buf.size();
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        sb.close();
        if (sb.errors == 0) begin
            $display("tb_utf8_typography_to_ascii: clean");
        end else begin
            $display("tb_utf8_typography_to_ascii: errors");
        end
        $finish;
    end
endmodule
